// ===== src/aes_pkg.sv =====
// ----------------------------------------------------------------------------
// AES package
// Payload types, register indexes, S-box tables and GF(2^8) helpers.
// ----------------------------------------------------------------------------
package aes_pkg;

	typedef struct packed {
		logic        op;
		logic [63:0] block_hi;
		logic [63:0] block_lo;
	} aes_in_t;

	typedef struct packed {
		logic [63:0] result_hi;
		logic [63:0] result_lo;
	} aes_out_t;

	typedef struct packed {
		logic [2:0]  index;
		logic [63:0] data;
	} aes_cfg_t;

	localparam logic [2:0] REG_KEY_SIZE  = 3'd0;
	localparam logic [2:0] REG_KEY_WORD0 = 3'd1;
	localparam logic [2:0] REG_KEY_WORD1 = 3'd2;
	localparam logic [2:0] REG_KEY_WORD2 = 3'd3;
	localparam logic [2:0] REG_KEY_WORD3 = 3'd4;

	localparam logic OP_ENCRYPT = 1'b0;
	localparam logic OP_DECRYPT = 1'b1;

	localparam logic [7:0] GF_POLY = 8'h1b;

	function automatic logic [7:0] sbox(input logic [7:0] a);
		logic [7:0] t [256];
		t = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
		return t[a];
	endfunction

	function automatic logic [7:0] inv_sbox(input logic [7:0] a);
		logic [7:0] t [256];
		t = '{
		8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
		8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
		8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
		8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
		8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
		8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
		8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
		8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
		8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
		8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
		8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
		8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
		8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
		8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
		8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
		8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
		return t[a];
	endfunction

	function automatic logic [7:0] xt(input logic [7:0] b);
		return {b[6:0], 1'b0} ^ (b[7] ? GF_POLY : 8'h00);
	endfunction

	// Forward column mix: coefficients 02 03 01 01
	function automatic logic [31:0] mix_col(input logic [31:0] c);
		logic [7:0] a [4];
		logic [31:0] r;
		for (int i = 0; i < 4; i++) a[i] = c[31-8*i -: 8];
		for (int i = 0; i < 4; i++)
			r[31-8*i -: 8] = xt(a[i]) ^ xt(a[(i+1)%4]) ^ a[(i+1)%4]
				^ a[(i+2)%4] ^ a[(i+3)%4];
		return r;
	endfunction

	// Inverse column mix: coefficients 0e 0b 0d 09
	function automatic logic [31:0] inv_mix_col(input logic [31:0] c);
		logic [7:0] a [4];
		logic [7:0] x2 [4];
		logic [7:0] x4 [4];
		logic [7:0] x8 [4];
		logic [31:0] r;
		for (int i = 0; i < 4; i++) begin
			a[i]  = c[31-8*i -: 8];
			x2[i] = xt(a[i]);
			x4[i] = xt(x2[i]);
			x8[i] = xt(x4[i]);
		end
		for (int i = 0; i < 4; i++)
			r[31-8*i -: 8] = (x8[i] ^ x4[i] ^ x2[i])
				^ (x8[(i+1)%4] ^ x2[(i+1)%4] ^ a[(i+1)%4])
				^ (x8[(i+2)%4] ^ x4[(i+2)%4] ^ a[(i+2)%4])
				^ (x8[(i+3)%4] ^ a[(i+3)%4]);
		return r;
	endfunction

	function automatic logic [31:0] sub_word(input logic [31:0] w);
		return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
	endfunction

	function automatic logic [7:0] rcon(input logic [3:0] i);
		logic [7:0] r;
		unique case (i)
			4'd0: r = 8'h01;
			4'd1: r = 8'h02;
			4'd2: r = 8'h04;
			4'd3: r = 8'h08;
			4'd4: r = 8'h10;
			4'd5: r = 8'h20;
			4'd6: r = 8'h40;
			4'd7: r = 8'h80;
			4'd8: r = 8'h1b;
			4'd9: r = 8'h36;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

endpackage

// ===== src/aes_ram.sv =====
// ----------------------------------------------------------------------------
// AES generic RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module aes_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 60
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// Write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== src/aes_block_cipher_top.sv =====
// ----------------------------------------------------------------------------
// AES block cipher top
// AES-128/192/256 encrypt and decrypt, one round per iteration, round keys
// expanded once into a word RAM and read one word per cycle.
// ----------------------------------------------------------------------------
// channel | dir | signals
// in      | in  | in_valid, in_ready, in_data (aes_in_t)
// out     | out | out_valid, out_ready, out_data (aes_out_t)
// cfg     | in  | cfg_valid, cfg_ready, cfg_data (aes_cfg_t)
//
// Key expansion after reset or any key-size or key-word write runs when the next
// block is taken, writing one schedule word per cycle.
// Each round key is fetched over the single round-key read port as four RAM
// reads and then applied; out_valid rises from the output register once the
// last round is done. The next block is taken once the sequencer is back in idle.
// The result sits in an output register; a finished block waits while an older
// result is stalled on the out channel.
module aes_block_cipher_top #(
	parameter int ROUND_KEY_WORDS = 60
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  aes_pkg::aes_in_t  in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output aes_pkg::aes_out_t out_data,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  aes_pkg::aes_cfg_t cfg_data
);
	import aes_pkg::*;

	localparam int AW = $clog2(ROUND_KEY_WORDS);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_EXP  = 5'b00010,
		ST_LOAD = 5'b00100,
		ST_RUN  = 5'b01000,
		ST_DONE = 5'b10000
	} state_t;

	state_t       state_q;
	logic [1:0]   key_size_q;
	logic [63:0]  key_q [4];
	logic         ready_q;
	logic [3:0]   nk_q;
	logic [3:0]   nr_q;
	logic [5:0]   widx_q;
	logic [3:0]   ncnt_q;
	logic [3:0]   rc_q;
	logic [31:0]  win_q [8];
	logic [127:0] st_q;
	logic         op_q;
	logic [3:0]   round_q;
	logic [2:0]   ph_q;
	logic [95:0]  ksel_q;
	aes_out_t     res_q;
	logic         oval_q;

	logic          we;
	logic [AW-1:0] waddr, raddr;
	logic [31:0]   wdata, rdata;

	aes_ram #(.WIDTH(32), .DEPTH(ROUND_KEY_WORDS)) u_rk (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);

	// Effective key size with fallback for a short store
	logic [1:0] sel_eff;
	always_comb begin
		sel_eff = (key_size_q[1]) ? 2'd2 : key_size_q;
		if (sel_eff == 2'd2 && ROUND_KEY_WORDS < 60) sel_eff = 2'd1;
		if (sel_eff == 2'd1 && ROUND_KEY_WORDS < 52) sel_eff = 2'd0;
	end

	logic [3:0] nk_new;
	assign nk_new = 4'd4 + {1'b0, sel_eff, 1'b0};

	// Next expanded word from the sliding window of the last Nk words
	logic [31:0] t_prev, t_mod, w_new;
	logic [31:0] win_nxt [8];
	always_comb begin
		t_prev = win_q[3'(nk_q - 4'd1)];
		t_mod = t_prev;
		if (ncnt_q == 4'd0) begin
			t_mod = sub_word({t_prev[23:0], t_prev[31:24]}) ^ {rcon(rc_q), 24'h0};
		end else if (nk_q > 4'd6 && ncnt_q == 4'd4) begin
			t_mod = sub_word(t_prev);
		end
		w_new = win_q[0] ^ t_mod;
		// Slide the window down and append the new word
		for (int i = 0; i < 7; i++) win_nxt[i] = win_q[i+1];
		win_nxt[7] = win_q[7];
		win_nxt[3'(nk_q - 4'd1)] = w_new;
	end

	logic [5:0] total;
	assign total = {nr_q, 2'b00} + 6'd4;

	// Round key assembled from three captured words and the one on the read port
	logic [127:0] key_full;
	logic [3:0]   round_step;
	assign key_full   = {ksel_q, rdata};
	assign round_step = op_q ? round_q - 4'd1 : round_q + 4'd1;

	// Round datapath
	logic [7:0]   sb [16];
	logic [127:0] shf, mix_k, fin_k;
	logic         last;
	always_comb begin
		shf = '0;
		for (int i = 0; i < 16; i++)
			sb[i] = op_q ? inv_sbox(st_q[127-8*i -: 8]) : sbox(st_q[127-8*i -: 8]);
		for (int r = 0; r < 4; r++)
			for (int c = 0; c < 4; c++) begin
				if (op_q)
					shf[127-8*(r+4*((c+r)%4)) -: 8] = sb[r+4*c];
				else
					shf[127-8*(r+4*c) -: 8] = sb[r+4*((c+r)%4)];
			end
		last = op_q ? (round_q == 4'd0) : (round_q == nr_q);
		for (int c = 0; c < 4; c++)
			mix_k[127-32*c -: 32] = op_q
				? inv_mix_col(shf[127-32*c -: 32] ^ key_full[127-32*c -: 32])
				: mix_col(shf[127-32*c -: 32]) ^ key_full[127-32*c -: 32];
		fin_k = last ? (shf ^ key_full) : mix_k;
	end

	// Round-key word address for the column being fetched
	logic [5:0] rd_idx;
	assign rd_idx = {round_q, ph_q[1:0]};
	assign raddr = rd_idx[AW-1:0];
	assign we    = (state_q == ST_EXP) && (widx_q < total);
	assign waddr = widx_q[AW-1:0];
	assign wdata = (widx_q < {2'b00, nk_q}) ? win_q[widx_q[2:0]] : w_new;

	logic res_load;
	assign res_load  = (state_q == ST_DONE) && (!oval_q || out_ready);
	assign in_ready  = (state_q == ST_IDLE) && !cfg_valid;
	assign cfg_ready = (state_q == ST_IDLE);
	assign out_valid = oval_q;
	assign out_data  = res_q;

	// Control sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			key_size_q <= '0;
			for (int i = 0; i < 4; i++) key_q[i] <= '0;
			ready_q    <= 1'b0;
			nk_q       <= '0;
			nr_q       <= '0;
			widx_q     <= '0;
			ncnt_q     <= '0;
			rc_q       <= '0;
			for (int i = 0; i < 8; i++) win_q[i] <= '0;
			st_q       <= '0;
			op_q       <= 1'b0;
			round_q    <= '0;
			ph_q       <= '0;
			ksel_q     <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cfg_valid && cfg_ready) begin
						if (cfg_data.index == REG_KEY_SIZE) begin
							key_size_q <= cfg_data.data[1:0];
							ready_q    <= 1'b0;
						end else if (cfg_data.index >= REG_KEY_WORD0 &&
							cfg_data.index <= REG_KEY_WORD3) begin
							key_q[2'(cfg_data.index - REG_KEY_WORD0)] <= cfg_data.data;
							ready_q <= 1'b0;
						end
					end else if (in_valid && in_ready) begin
						op_q <= in_data.op;
						st_q <= {in_data.block_hi, in_data.block_lo};
						ph_q <= '0;
						if (!ready_q) begin
							nk_q   <= nk_new;
							nr_q   <= nk_new + 4'd6;
							widx_q <= '0;
							ncnt_q <= '0;
							rc_q   <= '0;
							for (int i = 0; i < 8; i++)
								win_q[i] <= i[0] ? key_q[i>>1][31:0] : key_q[i>>1][63:32];
							state_q <= ST_EXP;
						end else begin
							round_q <= in_data.op ? nr_q : 4'd0;
							state_q <= ST_LOAD;
						end
					end
				end
				ST_EXP: begin
					// Write one schedule word per cycle
					if (widx_q < total) begin
						widx_q <= widx_q + 6'd1;
						if (widx_q >= {2'b00, nk_q}) begin
							for (int i = 0; i < 8; i++) win_q[i] <= win_nxt[i];
							if (ncnt_q == nk_q - 4'd1) begin
								ncnt_q <= '0;
								rc_q   <= rc_q + 4'd1;
							end else begin
								ncnt_q <= ncnt_q + 4'd1;
							end
						end
					end else begin
						ready_q <= 1'b1;
						round_q <= op_q ? nr_q : 4'd0;
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD, ST_RUN: begin
					// Fetch four key words, then apply the round
					if (ph_q == 3'd4) begin
						ph_q <= '0;
						if (state_q == ST_LOAD) begin
							st_q    <= st_q ^ key_full;
							round_q <= round_step;
							state_q <= ST_RUN;
						end else begin
							st_q <= fin_k;
							if (last) begin
								state_q <= ST_DONE;
							end else begin
								round_q <= round_step;
							end
						end
					end else begin
						ph_q <= ph_q + 3'd1;
						if (ph_q != 3'd0) ksel_q <= {ksel_q[63:0], rdata};
					end
				end
				ST_DONE: begin
					// Hold the block until the output register is free
					if (!oval_q || out_ready) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oval_q <= 1'b0;
			res_q  <= '0;
		end else if (res_load) begin
			oval_q <= 1'b1;
			res_q  <= aes_out_t'(st_q);
		end else if (out_valid && out_ready) begin
			oval_q <= 1'b0;
		end
	end

	// Checks
	a_no_in_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !in_ready) else $error("in_ready while busy");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
		else $error("result dropped under stall");
	a_done_raises_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) |=> out_valid) else $error("result lost");
endmodule

// ===== dv/aes_block_cipher_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES block cipher checker
// Watches the key-write, block and result channels, keeps its own copy of the
// key registers, expands the key schedule when needed, computes each expected
// block and compares every result beat in order.
// ----------------------------------------------------------------------------
module aes_block_cipher_checker #(
	parameter int ROUND_KEY_WORDS = 60
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_ready,
	input  aes_pkg::aes_in_t  in_data,
	input  logic              out_valid,
	input  logic              out_ready,
	input  aes_pkg::aes_out_t out_data,
	input  logic              cfg_valid,
	input  logic              cfg_ready,
	input  aes_pkg::aes_cfg_t cfg_data,
	output int                fail_count,
	output int                pending
);
	import aes_pkg::*;

	typedef logic [7:0] byte_arr_t [16];

	logic [1:0]  key_len_sel;
	logic [63:0] key_regs [4];
	logic [31:0] sched [ROUND_KEY_WORDS];
	logic        sched_valid;
	int          num_rounds;
	aes_out_t    expected_blocks [$];

	// Byte tables built once from GF(2^8) inversion and the affine map.
	logic [7:0] fwd_tbl [256];
	logic [7:0] inv_tbl [256];

	function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] acc;
		acc = 8'h00;
		while (a != 0) begin
			if (a[0]) acc ^= b;
			b = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
			a = a >> 1;
		end
		return acc;
	endfunction

	initial begin
		logic [7:0] x, inv, s;
		for (int v = 0; v < 256; v++) begin
			x = v[7:0];
			inv = 8'h00;
			for (int c = 1; c < 256; c++)
				if (gmul(x, c[7:0]) == 8'h01) inv = c[7:0];
			s = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]}
				^ {inv[4:0], inv[7:5]} ^ {inv[3:0], inv[7:4]} ^ 8'h63;
			fwd_tbl[v] = s;
			inv_tbl[s] = x;
		end
	end

	function automatic logic [31:0] sub_bytes_word(input logic [31:0] w);
		return {fwd_tbl[w[31:24]], fwd_tbl[w[23:16]], fwd_tbl[w[15:8]], fwd_tbl[w[7:0]]};
	endfunction

	// Build the round-key schedule for the selected key length.
	task automatic expand_schedule();
		int sel, nk, total;
		logic [31:0] t;
		logic [7:0]  rc;
		sel = (key_len_sel >= 2) ? 2 : key_len_sel;
		forever begin
			nk = 4 + 2 * sel;
			num_rounds = nk + 6;
			if (4 * (num_rounds + 1) <= ROUND_KEY_WORDS || sel == 0) break;
			sel--;
		end
		total = 4 * (num_rounds + 1);
		for (int i = 0; i < nk; i++)
			sched[i] = i[0] ? key_regs[(i >> 1) & 3][31:0] : key_regs[(i >> 1) & 3][63:32];
		for (int i = nk; i < total && i < ROUND_KEY_WORDS; i++) begin
			t = sched[i - 1];
			if (i % nk == 0) begin
				rc = 8'h01;
				for (int k = 1; k < ((i / nk - 1) % 10) + 1; k++)
					rc = {rc[6:0], 1'b0} ^ (rc[7] ? 8'h1b : 8'h00);
				t = sub_bytes_word({t[23:0], t[31:24]}) ^ {rc, 24'h0};
			end else if (nk > 6 && i % nk == 4) begin
				t = sub_bytes_word(t);
			end
			sched[i] = sched[i - nk] ^ t;
		end
		sched_valid = 1'b1;
	endtask

	function automatic byte_arr_t add_key(input byte_arr_t s, input int rnd);
		logic [31:0] w;
		for (int c = 0; c < 4; c++) begin
			w = (4 * rnd + c < ROUND_KEY_WORDS) ? sched[4 * rnd + c] : 32'h0;
			for (int r = 0; r < 4; r++) s[4 * c + r] ^= w[31 - 8 * r -: 8];
		end
		return s;
	endfunction

	function automatic byte_arr_t sub_all(input byte_arr_t s, input logic inverse);
		for (int i = 0; i < 16; i++) s[i] = inverse ? inv_tbl[s[i]] : fwd_tbl[s[i]];
		return s;
	endfunction

	function automatic byte_arr_t shift_all(input byte_arr_t s, input logic inverse);
		byte_arr_t t;
		int o;
		t = s;
		for (int r = 0; r < 4; r++)
			for (int c = 0; c < 4; c++) begin
				o = r + 4 * ((c + r) & 3);
				if (inverse) s[o] = t[r + 4 * c];
				else s[r + 4 * c] = t[o];
			end
		return s;
	endfunction

	function automatic byte_arr_t mix_all(input byte_arr_t s, input logic inverse);
		logic [7:0] col [4];
		logic [7:0] coef [4];
		logic [7:0] acc;
		if (inverse) coef = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
		else coef = '{8'h02, 8'h03, 8'h01, 8'h01};
		for (int c = 0; c < 4; c++) begin
			for (int k = 0; k < 4; k++) col[k] = s[4 * c + k];
			for (int r = 0; r < 4; r++) begin
				acc = 8'h00;
				for (int k = 0; k < 4; k++) acc ^= gmul(coef[(k - r) & 3], col[k]);
				s[4 * c + r] = acc;
			end
		end
		return s;
	endfunction

	function automatic aes_out_t cipher_block(input aes_in_t blk);
		byte_arr_t s;
		aes_out_t res;
		for (int i = 0; i < 8; i++) begin
			s[i]     = blk.block_hi[63 - 8 * i -: 8];
			s[8 + i] = blk.block_lo[63 - 8 * i -: 8];
		end
		if (blk.op != OP_DECRYPT) begin
			s = add_key(s, 0);
			for (int rnd = 1; rnd < num_rounds; rnd++)
				s = add_key(mix_all(shift_all(sub_all(s, 0), 0), 0), rnd);
			s = add_key(shift_all(sub_all(s, 0), 0), num_rounds);
		end else begin
			s = add_key(s, num_rounds);
			for (int rnd = num_rounds - 1; rnd > 0; rnd--)
				s = mix_all(add_key(sub_all(shift_all(s, 1), 1), rnd), 1);
			s = add_key(sub_all(shift_all(s, 1), 1), 0);
		end
		for (int i = 0; i < 8; i++) begin
			res.result_hi[63 - 8 * i -: 8] = s[i];
			res.result_lo[63 - 8 * i -: 8] = s[8 + i];
		end
		return res;
	endfunction

	task automatic report_mismatch(input string what);
		$display("[%0t] checker: %s", $realtime, what);
		fail_count++;
	endtask

	initial fail_count = 0;

	// Track key writes, predict each accepted block, compare each result beat.
	always @(posedge clk or negedge arst_n) begin
		aes_out_t exp_blk;
		if (!arst_n) begin
			key_len_sel = '0;
			for (int i = 0; i < 4; i++) key_regs[i] = '0;
			sched_valid = 1'b0;
			num_rounds  = 10;
			expected_blocks.delete();
			pending = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_data.index == REG_KEY_SIZE) begin
					key_len_sel = cfg_data.data[1:0];
					sched_valid = 1'b0;
				end else if (cfg_data.index <= REG_KEY_WORD3) begin
					key_regs[2'(cfg_data.index - REG_KEY_WORD0)] = cfg_data.data;
					sched_valid = 1'b0;
				end
			end
			if (in_valid && in_ready) begin
				if (!sched_valid) expand_schedule();
				expected_blocks.push_back(cipher_block(in_data));
			end
			if (out_valid && out_ready) begin
				if (expected_blocks.size() == 0) begin
					report_mismatch($sformatf("unexpected result %h", out_data));
				end else begin
					exp_blk = expected_blocks.pop_front();
					if (out_data.result_hi !== exp_blk.result_hi)
						report_mismatch($sformatf("result_hi %h, want %h",
							out_data.result_hi, exp_blk.result_hi));
					if (out_data.result_lo !== exp_blk.result_lo)
						report_mismatch($sformatf("result_lo %h, want %h",
							out_data.result_lo, exp_blk.result_lo));
				end
			end
			pending = expected_blocks.size();
		end
	end

endmodule

// ===== dv/aes_block_cipher_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES block cipher testbench
// Drives key writes between phases over every key length (including the
// out-of-range size and index), then directed and random blocks in both
// directions with random gaps and result stalls; the checker compares.
// ----------------------------------------------------------------------------
module aes_block_cipher_top_tb;
	import aes_pkg::*;

	localparam int  CYCLE_LIMIT = 1500000;
	localparam int  DRAIN_CYCLES = 200;
	localparam logic [2:0] REG_BAD_INDEX = 3'd7;

	logic     clk;
	logic     arst_n;
	logic     in_valid;
	logic     in_ready;
	aes_in_t  in_data;
	logic     out_valid;
	logic     out_ready;
	aes_out_t out_data;
	logic     cfg_valid;
	logic     cfg_ready;
	aes_cfg_t cfg_data;
	int       fail_count;
	int       pending;
	int       cycle_count;
	logic     stall_enable;

	aes_block_cipher_top u_top (
		.clk, .arst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready,
		.out_data, .cfg_valid, .cfg_ready, .cfg_data
	);

	aes_block_cipher_checker u_checker (
		.clk, .arst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready,
		.out_data, .cfg_valid, .cfg_ready, .cfg_data, .fail_count, .pending
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Mostly short gaps, now and then a long one.
	function automatic int gap_len();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 40) return 0;
		if (roll < 90) return $urandom_range(1, 4);
		return $urandom_range(10, 80);
	endfunction

	function automatic logic [63:0] rand_word();
		case ($urandom_range(0, 5))
			0: return 64'h0;
			1: return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	task automatic idle_cycles(input int n);
		repeat (n) @(negedge clk);
	endtask

	// Hold the beat from a falling edge until ready is seen ahead of a rising edge.
	task automatic write_key_reg(input logic [2:0] idx, input logic [63:0] val);
		cfg_valid = 1'b1;
		cfg_data  = '{index: idx, data: val};
		while (!cfg_ready) @(negedge clk);
		@(posedge clk);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic send_block(input logic op, input logic [63:0] hi, input logic [63:0] lo);
		if (stall_enable) idle_cycles(gap_len());
		in_valid = 1'b1;
		in_data  = '{op: op, block_hi: hi, block_lo: lo};
		while (!in_ready) @(negedge clk);
		@(posedge clk);
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	// Drain all results and let any key expansion settle before a write.
	task automatic wait_idle();
		while (pending != 0) @(negedge clk);
		idle_cycles(DRAIN_CYCLES);
	endtask

	task automatic load_key(input logic [1:0] len, input logic [63:0] k0, input logic [63:0] k1,
			input logic [63:0] k2, input logic [63:0] k3);
		wait_idle();
		write_key_reg(REG_KEY_WORD0, k0);
		write_key_reg(REG_KEY_WORD1, k1);
		write_key_reg(REG_KEY_WORD2, k2);
		write_key_reg(REG_KEY_WORD3, k3);
		write_key_reg(REG_KEY_SIZE, {62'h0, len});
	endtask

	// Randomly back-pressure results.
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (!stall_enable) begin
			out_ready <= 1'b1;
		end else begin
			case ($urandom_range(0, 19))
				0: out_ready <= 1'b0;
				1, 2, 3: out_ready <= ($urandom_range(0, 1) == 1);
				default: out_ready <= 1'b1;
			endcase
		end
	end

	// Give up on a hang.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		logic [63:0] k [4];
		cycle_count  = 0;
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		in_data      = '0;
		cfg_valid    = 1'b0;
		cfg_data     = '0;
		stall_enable = 1'b0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		// Reset key (all zero, 128-bit) with extreme blocks.
		send_block(OP_ENCRYPT, 64'h0, 64'h0);
		send_block(OP_DECRYPT, '1, '1);

		// Known 128-bit vector and its inverse.
		load_key(2'd0, 64'h0001020304050607, 64'h08090a0b0c0d0e0f, '1, '1);
		send_block(OP_ENCRYPT, 64'h0011223344556677, 64'h8899aabbccddeeff);
		send_block(OP_DECRYPT, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a);

		// 192-bit and 256-bit keys.
		load_key(2'd1, 64'h0001020304050607, 64'h08090a0b0c0d0e0f, 64'h1011121314151617, '0);
		send_block(OP_ENCRYPT, 64'h0011223344556677, 64'h8899aabbccddeeff);
		send_block(OP_DECRYPT, 64'hdda97ca4864cdfe0, 64'h6eaf70a0ec0d7191);
		load_key(2'd2, 64'h0001020304050607, 64'h08090a0b0c0d0e0f, 64'h1011121314151617,
			64'h18191a1b1c1d1e1f);
		send_block(OP_ENCRYPT, 64'h0011223344556677, 64'h8899aabbccddeeff);
		send_block(OP_DECRYPT, 64'h8ea2b7ca516745bf, 64'heafc49904b496089);

		// Key size three behaves as 256; all-ones key.
		load_key(2'd3, '1, '1, '1, '1);
		send_block(OP_ENCRYPT, '1, 64'h0);
		send_block(OP_DECRYPT, 64'h0, '1);

		// Out-of-range register index leaves the keys in place.
		wait_idle();
		write_key_reg(REG_BAD_INDEX, '1);
		send_block(OP_ENCRYPT, 64'h8000000000000001, 64'h0123456789abcdef);
		send_block(OP_DECRYPT, 64'h8000000000000001, 64'h0123456789abcdef);

		// Random phases: new key each phase, random traffic with stalls in all but every fifth phase.
		stall_enable = 1'b1;
		for (int phase = 0; phase < 40; phase++) begin
			for (int i = 0; i < 4; i++) k[i] = rand_word();
			load_key(phase == 39 ? 2'd0 : 2'($urandom_range(0, 3)), k[0], k[1], k[2], k[3]);
			if ($urandom_range(0, 3) == 0) write_key_reg(REG_BAD_INDEX, rand_word());
			stall_enable = (phase % 5 != 4);
			for (int n = 0; n < 40; n++)
				send_block(1'($urandom_range(0, 1)), rand_word(), rand_word());
		end

		wait_idle();
		if (fail_count == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
src/aes_pkg.sv
src/aes_ram.sv
src/aes_block_cipher_top.sv
dv/aes_block_cipher_checker.sv
dv/aes_block_cipher_top_tb.sv
